@@ hdl/lic_pkg.sv @@
// Shared types, constants and weight functions for the line integral convolution core
`timescale 1ns / 1ps

package lic_pkg;

    localparam int ROWS_DEF  = 64;
    localparam int COLS_DEF  = 64;
    localparam int STEPS_DEF = 10;

    localparam int FRAC     = 12;
    localparam int FLOW_W   = 16;
    localparam int MAG_W    = 15;
    localparam int FLOW_MAX = 16384;
    localparam int POS_W    = 24;
    localparam int CELL_W   = POS_W - FRAC;
    localparam int WT_W     = 17;
    localparam int WSUM_W   = 21;
    localparam int ACC_W    = 32;
    localparam int STEP_W   = FRAC + 2;

    // divider: numerator, denominator and quotient widths
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 22;
    localparam int DIV_QW = 13;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FADDR,
        ST_FDATA,
        ST_DIVR,
        ST_DIVC,
        ST_MOVE,
        ST_NADDR,
        ST_NDATA,
        ST_FIN,
        ST_FDIV
    } lic_state_t;

    // Unsigned 64-bit quotient by shift and subtract, for elaboration-time tables
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        begin
            r = '0;
            q = '0;
            for (int i = 63; i >= 0; i--)
            begin
                r = {r[63:0], a[i]};
                if (r >= {1'b0, b})
                begin
                    r    = r - {1'b0, b};
                    q[i] = 1'b1;
                end
            end
            udiv64 = q;
        end
    endfunction

    // Gaussian weight for step k in Q16, series expansion of exp(-k^2/sigma)
    function automatic logic [WT_W-1:0] weight_of(input int k, input int steps);
        logic [63:0] sigma;
        logic [63:0] t;
        logic [63:0] term;
        longint      sum;
        begin
            sigma = 64'(2 * steps * steps);
            t     = udiv64(64'(k * k) << 30, sigma);
            term  = 64'd1 << 30;
            sum   = longint'(1) << 30;
            for (int n = 1; n <= 20; n++)
            begin
                term = udiv64((term * t) >> 30, 64'(n));
                if ((n & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            weight_of = WT_W'((sum + (longint'(1) << 13)) >>> 14);
        end
    endfunction

    // All weights packed, step k at bits [k*WT_W +: WT_W]
    function automatic logic [16*WT_W-1:0] weight_table(input int steps);
        logic [16*WT_W-1:0] tab;
        begin
            tab = '0;
            for (int k = 0; k < 16; k++)
            begin
                if (k < steps)
                    tab[k*WT_W +: WT_W] = weight_of(k, steps);
            end
            weight_table = tab;
        end
    endfunction

    function automatic logic [WSUM_W-1:0] weight_total(input int steps);
        logic [WSUM_W-1:0] s;
        begin
            s = '0;
            for (int k = 0; k < 16; k++)
            begin
                if (k < steps)
                    s = s + WSUM_W'(weight_of(k, steps));
            end
            weight_total = s;
        end
    endfunction

    // Bring a cell coordinate a few cells outside the picture back into range
    function automatic logic [CELL_W:0] wrap_cell(input logic signed [CELL_W:0] v,
                                                   input int size);
        logic signed [CELL_W:0] r;
        begin
            r = v;
            if (v < 0)
                r = v + (CELL_W+1)'(size);
            else if (v >= (CELL_W+1)'(size))
                r = v - (CELL_W+1)'(size);
            wrap_cell = r;
        end
    endfunction

endpackage

@@ hdl/lic_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by step and final division
`timescale 1ns / 1ps

module lic_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lic_pkg::DIV_NW-1:0] num,
    input  logic [lic_pkg::DIV_DW-1:0] den,
    output logic                       done,
    output logic [lic_pkg::DIV_QW-1:0] quot
);

    localparam int NW = lic_pkg::DIV_NW;
    localparam int DW = lic_pkg::DIV_DW;
    localparam int QW = lic_pkg::DIV_QW;
    localparam int CW = $clog2(QW);

    logic [DW-1:0] rem_reg,   rem_next;
    logic [DW-1:0] den_reg,   den_next;
    logic [QW-1:0] low_reg,   low_next;
    logic [QW-1:0] quot_reg,  quot_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic          busy_reg,  busy_next;
    logic          done_reg,  done_next;

    logic [DW:0] shifted;
    logic [DW:0] diff;

    assign shifted = {rem_reg, low_reg[QW-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // upper numerator bits are known to lie below the divisor
            rem_next  = DW'(num[NW-1:QW]);
            den_next  = den;
            low_next  = num[QW-1:0];
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_next  = diff[DW-1:0];
                quot_next = {quot_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DW-1:0];
                quot_next = {quot_reg[QW-2:0], 1'b0};
            end
            low_next = {low_reg[QW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ hdl/line_integral_convolution_core.sv @@
// Top level of the line integral convolution core: stores, sequencer and output register
`timescale 1ns / 1ps

// Input channel: in_valid / in_stall carry one item per handshake. action 0 writes
// the flow vector and noise value of pixel (pix_row, pix_col) and gives
// no result. action 1 traces the streamline through that pixel STEPS steps forward
// and STEPS steps backward and returns the weighted noise mean on intensity.
// Output channel: out_valid / out_stall; the result sits in an output register and
// holds while out_stall is high.
// A query walks 2*STEPS steps, each with a flow read, two divisions on the shared
// divider and a noise read (no divisions where the flow is zero), and ends with a
// final division on the same divider.
// in_stall is high for the whole query; a query that finishes while the previous
// result is still stalled waits for the output register to drain.
// Reset clears the sequencer and the output valid; the pixel stores are not cleared
// and a pixel must be loaded before a query reads it.
module line_integral_convolution_core
#(
    parameter int ROWS  = lic_pkg::ROWS_DEF,
    parameter int COLS  = lic_pkg::COLS_DEF,
    parameter int STEPS = lic_pkg::STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [5:0]         pix_row,
    input  logic [5:0]         pix_col,
    input  logic signed [15:0] flow_row,
    input  logic signed [15:0] flow_col,
    input  logic [7:0]         noise_val,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         intensity
);

    localparam int FRAC   = lic_pkg::FRAC;
    localparam int POS_W  = lic_pkg::POS_W;
    localparam int CELL_W = lic_pkg::CELL_W;
    localparam int FW     = lic_pkg::FLOW_W;
    localparam int MW     = lic_pkg::MAG_W;
    localparam int WT_W   = lic_pkg::WT_W;
    localparam int ACC_W  = lic_pkg::ACC_W;
    localparam int SW     = lic_pkg::STEP_W;
    localparam int NW     = lic_pkg::DIV_NW;
    localparam int DW     = lic_pkg::DIV_DW;
    localparam int QW     = lic_pkg::DIV_QW;
    localparam int RW     = $clog2(ROWS);
    localparam int CLW    = $clog2(COLS);
    localparam int DEPTH  = ROWS * COLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int KW     = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [16*WT_W-1:0]          WTAB = lic_pkg::weight_table(STEPS);
    localparam logic [lic_pkg::WSUM_W-1:0]  WSUM = lic_pkg::weight_total(STEPS);

    logic [2*FW-1:0] flow_mem  [DEPTH];
    logic [7:0]      noise_mem [DEPTH];
    logic [2*FW-1:0] flow_rd_reg;
    logic [7:0]      noise_rd_reg;

    lic_pkg::lic_state_t state_reg, state_next;

    logic signed [POS_W-1:0] pos_r_reg,  pos_r_next;
    logic signed [POS_W-1:0] pos_c_reg,  pos_c_next;
    logic [RW-1:0]           start_r_reg, start_r_next;
    logic [CLW-1:0]          start_c_reg, start_c_next;
    logic                    dir_reg,    dir_next;
    logic [KW-1:0]           k_reg,      k_next;
    logic [ACC_W-1:0]        acc_reg,    acc_next;
    logic [MW-1:0]           ma_reg,     ma_next;
    logic [MW-1:0]           mb_reg,     mb_next;
    logic                    neg_r_reg,  neg_r_next;
    logic                    neg_c_reg,  neg_c_next;
    logic signed [SW-1:0]    step_r_reg, step_r_next;
    logic signed [SW-1:0]    step_c_reg, step_c_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              intensity_reg, intensity_next;

    logic          div_start;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_done;
    logic [QW-1:0] div_quot;

    lic_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // pixel coordinates folded into the picture
    logic [10:0]   row_mod, col_mod;
    logic [RW-1:0] in_r;
    logic [CLW-1:0] in_c;

    always_comb
    begin
        row_mod = 11'(pix_row);
        col_mod = 11'(pix_col);
        for (int i = 0; i < 4; i++)
        begin
            if (row_mod >= 11'(ROWS))
                row_mod = row_mod - 11'(ROWS);
            if (col_mod >= 11'(COLS))
                col_mod = col_mod - 11'(COLS);
        end
        in_r = RW'(row_mod);
        in_c = CLW'(col_mod);
    end

    // saturated flow components for loads
    logic signed [FW-1:0] ld_fr, ld_fc;

    always_comb
    begin
        ld_fr = flow_row;
        ld_fc = flow_col;
        if (flow_row > FW'(lic_pkg::FLOW_MAX))
            ld_fr = FW'(lic_pkg::FLOW_MAX);
        else if (flow_row < -FW'(lic_pkg::FLOW_MAX))
            ld_fr = -FW'(lic_pkg::FLOW_MAX);
        if (flow_col > FW'(lic_pkg::FLOW_MAX))
            ld_fc = FW'(lic_pkg::FLOW_MAX);
        else if (flow_col < -FW'(lic_pkg::FLOW_MAX))
            ld_fc = -FW'(lic_pkg::FLOW_MAX);
    end

    logic          ld_en;
    logic [AW-1:0] ld_addr;

    assign ld_en   = in_valid && !in_stall && !action;
    assign ld_addr = AW'(in_r) * AW'(COLS) + AW'(in_c);

    // read addresses from the current position
    logic signed [CELL_W:0] fl_r, fl_c, nz_r, nz_c;
    logic [CELL_W:0]        wfl_r, wfl_c, wnz_r, wnz_c;
    logic [AW-1:0]          flow_addr, noise_addr;

    always_comb
    begin
        fl_r = {pos_r_reg[POS_W-1], pos_r_reg[POS_W-1:FRAC]};
        fl_c = {pos_c_reg[POS_W-1], pos_c_reg[POS_W-1:FRAC]};
        nz_r = fl_r;
        nz_c = fl_c;
        // forward noise reads truncate toward zero
        if (!dir_reg)
        begin
            if (pos_r_reg[POS_W-1] && (pos_r_reg[FRAC-1:0] != '0))
                nz_r = fl_r + (CELL_W+1)'(1);
            if (pos_c_reg[POS_W-1] && (pos_c_reg[FRAC-1:0] != '0))
                nz_c = fl_c + (CELL_W+1)'(1);
        end
        wfl_r      = lic_pkg::wrap_cell(fl_r, ROWS);
        wfl_c      = lic_pkg::wrap_cell(fl_c, COLS);
        wnz_r      = lic_pkg::wrap_cell(nz_r, ROWS);
        wnz_c      = lic_pkg::wrap_cell(nz_c, COLS);
        flow_addr  = AW'(wfl_r) * AW'(COLS) + AW'(wfl_c);
        noise_addr = AW'(wnz_r) * AW'(COLS) + AW'(wnz_c);
    end

    always_ff @(posedge clk)
    begin
        if (ld_en)
        begin
            flow_mem[ld_addr]  <= {ld_fr, ld_fc};
            noise_mem[ld_addr] <= noise_val;
        end
        flow_rd_reg  <= flow_mem[flow_addr];
        noise_rd_reg <= noise_mem[noise_addr];
    end

    // stored flow, sign and magnitude
    logic signed [FW-1:0] rd_fr, rd_fc;
    logic [MW-1:0]        rd_ma, rd_mb;
    logic [WT_W-1:0]      wt_k;
    logic [WT_W+7:0]      prod;

    assign rd_fr = flow_rd_reg[2*FW-1:FW];
    assign rd_fc = flow_rd_reg[FW-1:0];
    assign rd_ma = rd_fr[FW-1] ? MW'(-rd_fr) : MW'(rd_fr);
    assign rd_mb = rd_fc[FW-1] ? MW'(-rd_fc) : MW'(rd_fc);
    assign wt_k  = WTAB[k_reg*WT_W +: WT_W];
    assign prod  = wt_k * noise_rd_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_r_next     = pos_r_reg;
        pos_c_next     = pos_c_reg;
        start_r_next   = start_r_reg;
        start_c_next   = start_c_reg;
        dir_next       = dir_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        neg_r_next     = neg_r_reg;
        neg_c_next     = neg_c_reg;
        step_r_next    = step_r_reg;
        step_c_next    = step_c_reg;
        out_valid_next = out_valid_reg;
        intensity_next = intensity_reg;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            lic_pkg::ST_IDLE:
            begin
                if (in_valid && action)
                begin
                    start_r_next = in_r;
                    start_c_next = in_c;
                    pos_r_next   = POS_W'(in_r) << FRAC;
                    pos_c_next   = POS_W'(in_c) << FRAC;
                    dir_next     = 1'b0;
                    k_next       = '0;
                    acc_next     = '0;
                    state_next   = lic_pkg::ST_FADDR;
                end
            end
            lic_pkg::ST_FADDR:
            begin
                state_next = lic_pkg::ST_FDATA;
            end
            lic_pkg::ST_FDATA:
            begin
                ma_next    = rd_ma;
                mb_next    = rd_mb;
                neg_r_next = rd_fr[FW-1] ^ dir_reg;
                neg_c_next = rd_fc[FW-1] ^ dir_reg;
                if ((rd_ma == '0) && (rd_mb == '0))
                begin
                    // zero flow: stay put
                    step_r_next = '0;
                    step_c_next = '0;
                    state_next  = lic_pkg::ST_MOVE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = NW'(rd_ma) << FRAC;
                    div_den    = DW'(rd_ma) + DW'(rd_mb);
                    state_next = lic_pkg::ST_DIVR;
                end
            end
            lic_pkg::ST_DIVR:
            begin
                if (div_done)
                begin
                    step_r_next = neg_r_reg ? -SW'(div_quot) : SW'(div_quot);
                    div_start   = 1'b1;
                    div_num     = NW'(mb_reg) << FRAC;
                    div_den     = DW'(ma_reg) + DW'(mb_reg);
                    state_next  = lic_pkg::ST_DIVC;
                end
            end
            lic_pkg::ST_DIVC:
            begin
                if (div_done)
                begin
                    step_c_next = neg_c_reg ? -SW'(div_quot) : SW'(div_quot);
                    state_next  = lic_pkg::ST_MOVE;
                end
            end
            lic_pkg::ST_MOVE:
            begin
                pos_r_next = pos_r_reg + POS_W'(step_r_reg);
                pos_c_next = pos_c_reg + POS_W'(step_c_reg);
                state_next = lic_pkg::ST_NADDR;
            end
            lic_pkg::ST_NADDR:
            begin
                state_next = lic_pkg::ST_NDATA;
            end
            lic_pkg::ST_NDATA:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                state_next = lic_pkg::ST_FADDR;
                if (k_reg == KW'(STEPS-1))
                begin
                    k_next = '0;
                    if (dir_reg)
                        state_next = lic_pkg::ST_FIN;
                    else
                    begin
                        // restart from the query pixel, walking backward
                        dir_next   = 1'b1;
                        pos_r_next = POS_W'(start_r_reg) << FRAC;
                        pos_c_next = POS_W'(start_c_reg) << FRAC;
                    end
                end
                else
                    k_next = k_reg + 1'b1;
            end
            lic_pkg::ST_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg)
                begin
                    div_start  = 1'b1;
                    div_num    = NW'(acc_reg) + NW'(WSUM);
                    div_den    = DW'(WSUM) << 1;
                    state_next = lic_pkg::ST_FDIV;
                end
            end
            lic_pkg::ST_FDIV:
            begin
                if (div_done)
                begin
                    intensity_next = (div_quot > QW'(255)) ? 8'hFF : div_quot[7:0];
                    out_valid_next = 1'b1;
                    state_next     = lic_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lic_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lic_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            dir_reg       <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            dir_reg       <= dir_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_r_reg     <= pos_r_next;
        pos_c_reg     <= pos_c_next;
        start_r_reg   <= start_r_next;
        start_c_reg   <= start_c_next;
        acc_reg       <= acc_next;
        ma_reg        <= ma_next;
        mb_reg        <= mb_next;
        neg_r_reg     <= neg_r_next;
        neg_c_reg     <= neg_c_next;
        step_r_reg    <= step_r_next;
        step_c_reg    <= step_c_next;
        intensity_reg <= intensity_next;
    end

    assign in_stall  = (state_reg != lic_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign intensity = intensity_reg;

endmodule

@@ tb/sv/tb_line_integral_convolution_core.sv @@
// Testbench for the line integral convolution core: random loads and queries vs. a streamline predictor
`timescale 1ns / 1ps

module tb_line_integral_convolution_core;

    localparam int         NROWS     = 64;
    localparam int         NCOLS     = 64;
    localparam int         NSTEPS    = 10;
    localparam int         PFRAC     = 12;
    localparam int         FLOW_LIM  = 16384;
    localparam int         QUERY_LAT = 800;
    localparam longint     MAX_CYCLES = 4000000;
    localparam logic       ACT_LOAD  = 1'b0;
    localparam logic       ACT_QUERY = 1'b1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [5:0]         pix_row;
    logic [5:0]         pix_col;
    logic signed [15:0] flow_row;
    logic signed [15:0] flow_col;
    logic [7:0]         noise_val;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         intensity;

    line_integral_convolution_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .pix_row   (pix_row),
        .pix_col   (pix_col),
        .flow_row  (flow_row),
        .flow_col  (flow_col),
        .noise_val (noise_val),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .intensity (intensity)
    );

    // predictor state
    shortint    pix_fr [NROWS*NCOLS];
    shortint    pix_fc [NROWS*NCOLS];
    byte        pix_noise [NROWS*NCOLS];
    bit         pix_loaded [NROWS*NCOLS];
    longint     gauss_w [NSTEPS];
    longint     gauss_total;

    logic [7:0] intensity_q [$];
    int         errors;
    longint     cycle_cnt;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_off;
    int         sent_cnt;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void build_gauss();
        longint unsigned sig, t, term;
        longint          acc;
        begin
            sig = 2 * NSTEPS * NSTEPS;
            gauss_total = 0;
            for (int k = 0; k < NSTEPS; k++)
            begin
                t    = (longint'(k * k) << 30) / sig;
                term = 64'd1 << 30;
                acc  = longint'(1) << 30;
                for (int n = 1; n <= 20; n++)
                begin
                    term = ((term * t) >> 30) / n;
                    if (n % 2 == 1)
                        acc = acc - longint'(term);
                    else
                        acc = acc + longint'(term);
                end
                if (acc < 0)
                    acc = 0;
                gauss_w[k] = (acc + (longint'(1) << 13)) >>> 14;
                gauss_total += gauss_w[k];
            end
        end
    endfunction

    function automatic longint wrap_to(longint q, longint size);
        longint m;
        begin
            m = q % size;
            if (m < 0)
                m += size;
            return m;
        end
    endfunction

    function automatic longint toward_zero(longint p);
        begin
            if (p >= 0)
                return p >>> PFRAC;
            return -((-p) >>> PFRAC);
        end
    endfunction

    function automatic longint unit_step(longint a, longint b);
        longint ma, mb, s;
        begin
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            if (a == 0)
                return 0;
            s = (ma << PFRAC) / (ma + mb);
            return (a < 0) ? -s : s;
        end
    endfunction

    // Walk one direction of the streamline; flag the first unloaded pixel it reads
    function automatic longint trace_line(int r, int c, bit backward,
                                          output bit miss, output int miss_idx);
        longint pr, pc, acc, fr, fc, ar, ac, nr, nc;
        begin
            pr = longint'(r) << PFRAC;
            pc = longint'(c) << PFRAC;
            acc = 0;
            miss = 1'b0;
            miss_idx = 0;
            for (int k = 0; k < NSTEPS; k++)
            begin
                ar = wrap_to(pr >>> PFRAC, NROWS);
                ac = wrap_to(pc >>> PFRAC, NCOLS);
                if (!pix_loaded[ar*NCOLS+ac])
                begin
                    miss = 1'b1;
                    miss_idx = int'(ar*NCOLS+ac);
                    return 0;
                end
                fr = pix_fr[ar*NCOLS+ac];
                fc = pix_fc[ar*NCOLS+ac];
                if (backward)
                begin
                    fr = -fr;
                    fc = -fc;
                end
                pr += unit_step(fr, fc);
                pc += unit_step(fc, fr);
                if (backward)
                begin
                    nr = wrap_to(pr >>> PFRAC, NROWS);
                    nc = wrap_to(pc >>> PFRAC, NCOLS);
                end
                else
                begin
                    nr = wrap_to(toward_zero(pr), NROWS);
                    nc = wrap_to(toward_zero(pc), NCOLS);
                end
                if (!pix_loaded[nr*NCOLS+nc])
                begin
                    miss = 1'b1;
                    miss_idx = int'(nr*NCOLS+nc);
                    return 0;
                end
                acc += gauss_w[k] * longint'($unsigned(pix_noise[nr*NCOLS+nc]));
            end
            return acc;
        end
    endfunction

    function automatic longint saturate_flow(logic signed [15:0] v);
        begin
            if (v > FLOW_LIM)
                return FLOW_LIM;
            if (v < -FLOW_LIM)
                return -FLOW_LIM;
            return v;
        end
    endfunction

    // Update the predictor for one accepted item
    task automatic predict_item(logic act, logic [5:0] r, logic [5:0] c,
                                logic signed [15:0] fr, logic signed [15:0] fc,
                                logic [7:0] nv);
        int     idx;
        bit     m1, m2;
        int     i1, i2;
        longint s, v;
        begin
            idx = int'(r) * NCOLS + int'(c);
            if (act == ACT_LOAD)
            begin
                pix_fr[idx] = shortint'(saturate_flow(fr));
                pix_fc[idx] = shortint'(saturate_flow(fc));
                pix_noise[idx] = byte'(nv);
                pix_loaded[idx] = 1'b1;
            end
            else
            begin
                s = trace_line(r, c, 1'b0, m1, i1) + trace_line(r, c, 1'b1, m2, i2);
                v = (s + gauss_total) / (2 * gauss_total);
                if (v > 255)
                    v = 255;
                intensity_q.push_back(8'(v));
            end
        end
    endtask

    task automatic send_item(logic act, logic [5:0] r, logic [5:0] c,
                             logic signed [15:0] fr, logic signed [15:0] fc,
                             logic [7:0] nv);
        int gap;
        begin
            in_valid  <= 1'b1;
            action    <= act;
            pix_row   <= r;
            pix_col   <= c;
            flow_row  <= fr;
            flow_col  <= fc;
            noise_val <= nv;
            do
                @(posedge clk);
            while (in_stall);
            predict_item(act, r, c, fr, fc, nv);
            sent_cnt++;
            if ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                gap = $urandom_range(6, 1);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic signed [15:0] rand_flow();
        int sel;
        begin
            sel = $urandom_range(99);
            if (sel < 8)
                return 16'sd0;
            if (sel < 16)
                return 16'($urandom);
            if (sel < 22)
                return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
            return 16'($signed($urandom_range(2*FLOW_LIM)) - FLOW_LIM);
        end
    endfunction

    // Load every pixel the streamline would read before the query goes out
    task automatic query_pixel(logic [5:0] r, logic [5:0] c, bit still_fill);
        bit m;
        int idx;
        longint dummy;
        begin
            forever
            begin
                dummy = trace_line(r, c, 1'b0, m, idx);
                if (!m)
                    dummy = trace_line(r, c, 1'b1, m, idx);
                if (!m)
                    break;
                if (still_fill)
                    send_item(ACT_LOAD, 6'(idx / NCOLS), 6'(idx % NCOLS), 16'sd0, 16'sd0,
                              8'($urandom));
                else
                    send_item(ACT_LOAD, 6'(idx / NCOLS), 6'(idx % NCOLS), rand_flow(),
                              rand_flow(), 8'($urandom));
            end
            send_item(ACT_QUERY, r, c, 16'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic wait_results();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (intensity_q.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic test_directed();
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            // zero flow: the walk stays on its own pixel
            send_item(ACT_LOAD, 6'd0, 6'd0, 16'sd0, 16'sd0, 8'd255);
            send_item(ACT_LOAD, 6'd63, 6'd63, 16'sd0, 16'sd0, 8'd0);
            query_pixel(6'd0, 6'd0, 1'b1);
            query_pixel(6'd63, 6'd63, 1'b1);
            // full-scale and saturating components, walks wrap across the edges
            send_item(ACT_LOAD, 6'd63, 6'd0, 16'sd16384, -16'sd16384, 8'd128);
            send_item(ACT_LOAD, 6'd0, 6'd63, 16'sh7FFF, 16'sh8000, 8'd1);
            send_item(ACT_LOAD, 6'd32, 6'd32, 16'sd0, -16'sd16384, 8'd77);
            send_item(ACT_LOAD, 6'd31, 6'd1, 16'sh8000, 16'sd0, 8'd200);
            query_pixel(6'd63, 6'd0, 1'b1);
            query_pixel(6'd0, 6'd63, 1'b1);
            query_pixel(6'd32, 6'd32, 1'b1);
            query_pixel(6'd31, 6'd1, 1'b1);
            wait_results();
        end
    endtask

    task automatic test_random(int n_items, int idle_pct, int stall_pct);
        int start_cnt;
        begin
            send_idle_pct = idle_pct;
            recv_stall_pct = stall_pct;
            start_cnt = sent_cnt;
            while (sent_cnt - start_cnt < n_items)
            begin
                if ($urandom_range(99) < 25)
                    query_pixel(6'($urandom), 6'($urandom), 1'b0);
                else
                    send_item(ACT_LOAD, 6'($urandom), 6'($urandom), rand_flow(),
                              rand_flow(), 8'($urandom));
            end
            wait_results();
        end
    endtask

    // Hold the output long enough for queries to pile up behind the result register
    task automatic test_backpressure();
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            hold_off = 3000;
            for (int i = 0; i < 6; i++)
                query_pixel(6'($urandom), 6'($urandom), 1'b0);
            wait_results();
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (intensity_q.size() == 0)
            begin
                $display("%0t: unexpected result intensity=%0d", $time, intensity);
                errors++;
            end
            else
            begin
                if (intensity !== intensity_q[0])
                begin
                    $display("%0t: intensity mismatch expected=%0d actual=%0d",
                             $time, intensity_q[0], intensity);
                    errors++;
                end
                void'(intensity_q.pop_front());
            end
        end
    end

    // Drive the output stall; count down a long hold-off cycle by cycle
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycle_cnt = 0;
        hold_off = 0;
        sent_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NROWS*NCOLS; i++)
            pix_loaded[i] = 1'b0;
        build_gauss();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = ACT_LOAD;
        pix_row = '0;
        pix_col = '0;
        flow_row = '0;
        flow_col = '0;
        noise_val = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250, 0, 0);
        test_random(250, 71, 0);
        test_random(250, 0, 71);
        test_backpressure();
        test_random(250, 24, 24);

        in_valid <= 1'b0;
        repeat (QUERY_LAT) @(posedge clk);
        if (errors == 0 && intensity_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
